### rtl/core/rrtd_pkg.sv
package rrtd_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int KEY_W = 8;
	localparam int LEN_W = 16;
	localparam int TIME_W = 32;
	localparam logic [LEN_W-1:0] QUANTUM_RESET = 16'd10;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	// Best candidate and bookkeeping handed from one cell to the next.
	typedef struct packed {
		logic             valid;
		logic             many;
		logic             free_found;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] turns;
		logic [LEN_W-1:0] rem;
	} cand_t;

	// Write command broadcast to every cell; only the selected cell acts.
	typedef struct packed {
		logic             load;
		logic             upd;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] rem;
	} cell_cmd_t;

endpackage

### rtl/core/rrtd_cell.sv
module rrtd_cell #(
	parameter int IDX_W = 4,
	parameter int SLOT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sel,
	input  rrtd_pkg::cell_cmd_t cmd,
	input  rrtd_pkg::cand_t    cand_in,
	input  logic [IDX_W-1:0]   best_idx_in,
	input  logic [IDX_W-1:0]   free_idx_in,
	output rrtd_pkg::cand_t    cand_out,
	output logic [IDX_W-1:0]   best_idx_out,
	output logic [IDX_W-1:0]   free_idx_out
);
	import rrtd_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] turns_q;

	cand_t            cand_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] free_idx_q;

	cand_t            cand_d;
	logic [IDX_W-1:0] best_idx_d;
	logic [IDX_W-1:0] free_idx_d;
	logic             mine_better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.load) begin
			valid_q <= 1'b1;
		end else if (sel && cmd.upd && cmd.rem == '0) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.load) begin
			key_q <= cmd.key;
			rem_q <= cmd.rem;
			turns_q <= '0;
		end else if (sel && cmd.upd) begin
			rem_q <= cmd.rem;
			if (turns_q != '1) begin
				turns_q <= turns_q + 1'b1;
			end
		end
	end

	always_comb begin
		mine_better = valid_q && (!cand_in.valid || turns_q < cand_in.turns ||
			(turns_q == cand_in.turns && key_q < cand_in.key));
		cand_d = cand_in;
		best_idx_d = best_idx_in;
		free_idx_d = free_idx_in;
		cand_d.many = cand_in.many || (cand_in.valid && valid_q);
		if (mine_better) begin
			cand_d.valid = 1'b1;
			cand_d.key = key_q;
			cand_d.turns = turns_q;
			cand_d.rem = rem_q;
			best_idx_d = MY_IDX;
		end
		if (!cand_in.free_found && !valid_q) begin
			cand_d.free_found = 1'b1;
			free_idx_d = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			best_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			cand_q <= cand_d;
			best_idx_q <= best_idx_d;
			free_idx_q <= free_idx_d;
		end
	end

	assign cand_out = cand_q;
	assign best_idx_out = best_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

### rtl/core/round_robin_task_dispatcher_unit.sv
// Each item is accepted on start when busy is low, and busy then stays high while the scan runs through every cell.
// A dispatch result is strobed on done in the same cycle that busy falls; an add gives no strobe.
// A new item cannot be taken until the scan of the last one through the candidate chain of cells has ended.
// Results cannot be stalled by the receiver; done is high for exactly one cycle.
// Reset clears the task table, the time and switch counters, and sets the quantum to ten.
module round_robin_task_dispatcher_unit #(
	parameter int MAX_TASKS = rrtd_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        mode,
	input  logic [7:0]  name_key,
	input  logic [15:0] burst_len,
	output logic        done,
	output logic [7:0]  task_key,
	output logic [31:0] slice_start,
	output logic [15:0] slice_len,
	output logic        first_run,
	output logic        finished,
	output logic        switch_follows,
	output logic [31:0] switch_count,
	output logic        idle
);
	import rrtd_pkg::*;

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(MAX_TASKS - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  burst_q;
	logic [LEN_W-1:0]  quantum_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] switches_q;

	logic              done_q;
	logic [KEY_W-1:0]  task_key_q;
	logic [TIME_W-1:0] slice_start_q;
	logic [LEN_W-1:0]  slice_len_q;
	logic              first_run_q;
	logic              finished_q;
	logic              switch_follows_q;
	logic [TIME_W-1:0] switch_count_q;
	logic              idle_q;

	cand_t             cand_w [MAX_TASKS+1];
	logic [IDX_W-1:0]  best_w [MAX_TASKS+1];
	logic [IDX_W-1:0]  free_w [MAX_TASKS+1];
	logic [MAX_TASKS-1:0] sel;
	cell_cmd_t         cmd;

	cand_t             tail;
	logic              commit;
	logic [LEN_W-1:0]  q_eff;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  new_rem;
	logic              task_done;
	logic              more;
	logic [TIME_W:0]   time_sum;
	logic [TIME_W-1:0] time_next;
	logic [TIME_W-1:0] switches_next;

	assign cand_w[0] = '0;
	assign best_w[0] = '0;
	assign free_w[0] = '0;

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		rrtd_cell #(
			.IDX_W(IDX_W),
			.SLOT (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.sel         (sel[i]),
			.cmd         (cmd),
			.cand_in     (cand_w[i]),
			.best_idx_in (best_w[i]),
			.free_idx_in (free_w[i]),
			.cand_out    (cand_w[i+1]),
			.best_idx_out(best_w[i+1]),
			.free_idx_out(free_w[i+1])
		);
	end

	assign tail = cand_w[MAX_TASKS];
	assign commit = (state_q == ST_SCAN) && (cnt_q == LAST_CNT);

	always_comb begin
		q_eff = (quantum_q == '0) ? LEN_W'(1) : quantum_q;
		len = (tail.rem < q_eff) ? tail.rem : q_eff;
		new_rem = tail.rem - len;
		task_done = (new_rem == '0);
		more = task_done ? tail.many : 1'b1;
		time_sum = {1'b0, time_q} + {{(TIME_W+1-LEN_W){1'b0}}, len};
		time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
		switches_next = (more && switches_q != '1) ? switches_q + 1'b1 : switches_q;
		cmd.load = (mode_q == MODE_ADD);
		cmd.upd = (mode_q == MODE_DISPATCH);
		cmd.key = key_q;
		cmd.rem = (mode_q == MODE_ADD) ? burst_q : new_rem;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (mode_q == MODE_ADD) begin
				sel[i] = commit && tail.free_found && burst_q != '0 &&
					free_w[MAX_TASKS] == IDX_W'(i);
			end else begin
				sel[i] = commit && tail.valid && best_w[MAX_TASKS] == IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			time_q <= '0;
			switches_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (commit) begin
						state_q <= ST_IDLE;
						if (mode_q == MODE_DISPATCH) begin
							done_q <= 1'b1;
							if (tail.valid) begin
								time_q <= time_next;
								switches_q <= switches_next;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= mode;
			key_q <= name_key;
			burst_q <= burst_len;
		end
		if (commit) begin
			if (tail.valid) begin
				task_key_q <= tail.key;
				slice_start_q <= time_q;
				slice_len_q <= len;
				first_run_q <= (tail.turns == '0);
				finished_q <= task_done;
				switch_follows_q <= more;
				switch_count_q <= switches_next;
				idle_q <= 1'b0;
			end else begin
				task_key_q <= '0;
				slice_start_q <= '0;
				slice_len_q <= '0;
				first_run_q <= 1'b0;
				finished_q <= 1'b0;
				switch_follows_q <= 1'b0;
				switch_count_q <= '0;
				idle_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q == ST_SCAN);
	assign done = done_q;
	assign task_key = task_key_q;
	assign slice_start = slice_start_q;
	assign slice_len = slice_len_q;
	assign first_run = first_run_q;
	assign finished = finished_q;
	assign switch_follows = switch_follows_q;
	assign switch_count = switch_count_q;
	assign idle = idle_q;

endmodule
